/* hw/rtl/disparity_smooth_depth_convert_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the disparity to depth converter
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_SMOOTH_DEPTH_CONVERT_TOP_ASSERT_SVH
`define DISPARITY_SMOOTH_DEPTH_CONVERT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define DSDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define DSDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/dsdc_pkg.sv */
// ----------------------------------------------------------------------------
// dsdc_pkg
// Shared widths, register codes, reset values and sideband types.
// ----------------------------------------------------------------------------
package dsdc_pkg;

    localparam int DISP_W     = 16;
    localparam int SMOOTH_W   = 15;
    localparam int DEPTH_W    = 16;
    localparam int LEVEL_W    = 8;
    localparam int WEIGHT_W   = 9;
    localparam int NUM_W      = 32;
    localparam int OFFSET_W   = 16;
    localparam int GAIN_W     = 24;
    localparam int FRAME_W    = 19;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Quotient width and divider stage split
    localparam int QUOT_W     = 16;
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = QUOT_W / DIV_STAGES;

    // Blend arithmetic
    localparam int BLEND_SUM_W = 24;
    localparam int BLEND_SHIFT = 8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 9'd256;
    localparam logic [BLEND_SUM_W-1:0] BLEND_ROUND = 24'd128;

    // Display level arithmetic
    localparam int LVL_PROD_W = 42;
    localparam int LVL_SHIFT  = 16;

    // Register reset values
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd179;
    localparam logic [NUM_W-1:0]    NUM_RST    = 32'd1280000;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd0;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd9325;
    localparam int                  FRAME_RST  = 102400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMA_WEIGHT   = 3'd0,
        REG_DEPTH_NUM    = 3'd1,
        REG_NORM_OFFSET  = 3'd2,
        REG_NORM_GAIN    = 3'd3,
        REG_FRAME_PIXELS = 3'd4
    } cfg_reg_t;

    // Fields that ride alongside the divider
    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [SMOOTH_W-1:0] smooth;
        logic                last;
        logic                no_depth;
        logic                sat;
    } side_t;

endpackage

/* hw/rtl/dsdc_if.sv */
// ----------------------------------------------------------------------------
// dsdc_in_if / dsdc_out_if
// Valid/ready stream channels for disparity pixels and results.
// ----------------------------------------------------------------------------
interface dsdc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [dsdc_pkg::DISP_W-1:0]  disparity;
    logic                                frame_start;

    modport source (output valid, output disparity, output frame_start, input ready);
    modport sink   (input valid, input disparity, input frame_start, output ready);
endinterface

interface dsdc_out_if;
    logic                              valid;
    logic                              ready;
    logic [dsdc_pkg::DEPTH_W-1:0]      depth_mm;
    logic [dsdc_pkg::LEVEL_W-1:0]      display_level;
    logic [dsdc_pkg::SMOOTH_W-1:0]     smoothed_disparity;
    logic                              frame_end;

    modport source (output valid, output depth_mm, output display_level,
                    output smoothed_disparity, output frame_end, input ready);
    modport sink   (input valid, input depth_mm, input display_level,
                    input smoothed_disparity, input frame_end, output ready);
endinterface

/* hw/rtl/disparity_smooth_depth_convert_top.sv */
// ----------------------------------------------------------------------------
// disparity_smooth_depth_convert_top
// Clamps disparity, blends it with the previous frame, converts to depth and
// a display level.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  pix_in    sink       disparity, frame_start
//  pix_out   source     depth_mm, display_level, smoothed_disparity, frame_end
//  wr_*      in         register writes (index, 32-bit data)
//
//  One item per cycle while pix_out accepts; 11 register stages from input to
//  result: accept/store read, blend and store write, depth/level prep, then 8
//  divider stages (2 bits each), the first of which also rounds and saturates
//  the level.
//  One enable moves every stage; pix_out not ready holds the whole pipe.
//  The frame store has no reset; reset clears control state only.
//  Back-to-back reads of a pixel just written are forwarded from the blend stage.
// ----------------------------------------------------------------------------
module disparity_smooth_depth_convert_top #(
    parameter int MAX_PIXELS          = 262144,
    parameter int DISPARITY_FRAC_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dsdc_in_if.sink                           pix_in,
    dsdc_out_if.source                        pix_out,
    input  logic                              wr_en,
    input  logic [dsdc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [dsdc_pkg::CFG_DATA_W-1:0]   wr_data
);

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int SW = dsdc_pkg::SMOOTH_W;
    localparam logic [SW-1:0] ONE_PX = SW'(2 ** DISPARITY_FRAC_BITS);
    localparam logic [AW-1:0] FRAME_LAST_RST =
        AW'(((dsdc_pkg::FRAME_RST > MAX_PIXELS) ? MAX_PIXELS : dsdc_pkg::FRAME_RST) - 1);

    // Configuration and frame state
    logic [dsdc_pkg::WEIGHT_W-1:0] weight_reg;
    logic [dsdc_pkg::NUM_W-1:0]    num_reg;
    logic [dsdc_pkg::OFFSET_W-1:0] offset_reg;
    logic [dsdc_pkg::GAIN_W-1:0]   gain_reg;
    logic [AW-1:0]                 frame_last_reg;
    logic [AW-1:0]                 frame_last_next;
    logic [dsdc_pkg::WEIGHT_W-1:0] weight_next;
    logic [AW-1:0]                 pixel_index_reg;
    logic                          seeded_reg;

    // Accept stage
    logic          en;
    logic          accept;
    logic [SW-1:0] cur_in;
    logic [AW-1:0] idx_raw;
    logic [AW-1:0] idx_in;
    logic          last_in;
    logic          wr_in;

    // Stage 1: blend and store write
    logic          v1_reg;
    logic          hit1_reg;
    logic [AW-1:0] idx1_reg;
    logic [SW-1:0] cur1_reg;
    logic          last1_reg;
    logic          wr1_reg;
    logic          blend1_reg;
    logic [SW-1:0] rd_reg;
    logic [SW-1:0] prev1;
    logic [dsdc_pkg::WEIGHT_W-1:0]    w_inv;
    logic [dsdc_pkg::BLEND_SUM_W-1:0] blend_sum;
    logic [SW-1:0] s1;
    logic [SW-1:0] mem [MAX_PIXELS];

    // Stage 2: depth dividend and level product
    logic                                       v2_reg;
    logic [SW-1:0]                              s2_reg;
    logic                                       last2_reg;
    logic [dsdc_pkg::NUM_W:0]                   n_sum;
    logic signed [SW+1:0]                       lvl_diff;
    logic signed [dsdc_pkg::LVL_PROD_W-1:0]     lvl_prod;

    // Stage 3: level saturate, divider feed
    logic                                       v3_reg;
    logic [SW-1:0]                              s3_reg;
    logic                                       last3_reg;
    logic                                       zero3_reg;
    logic                                       sat3_reg;
    logic [dsdc_pkg::QUOT_W-1:0]                lo3_reg;
    logic [SW-1:0]                              rem3_reg;
    logic signed [dsdc_pkg::LVL_PROD_W-1:0]     lvl_prod3_reg;
    logic signed [dsdc_pkg::LVL_PROD_W-1:0]     lvl_sum;
    logic [dsdc_pkg::LEVEL_W-1:0]               level3;
    dsdc_pkg::side_t                            side3;

    // Divider outputs
    logic                        dv_valid;
    logic [dsdc_pkg::QUOT_W-1:0] dv_quot;
    dsdc_pkg::side_t             dv_side;

    // Global advance
    assign en           = !dv_valid || pix_out.ready;
    assign pix_in.ready = en;
    assign accept       = pix_in.valid && en;

    // Decode register write values
    always_comb
    begin
        weight_next = wr_data[dsdc_pkg::WEIGHT_W-1:0];
        if (weight_next > dsdc_pkg::WEIGHT_MAX)
        begin
            weight_next = dsdc_pkg::WEIGHT_MAX;
        end
        if (wr_data[dsdc_pkg::FRAME_W-1:0] == '0)
        begin
            frame_last_next = '0;
        end
        else if (32'(wr_data[dsdc_pkg::FRAME_W-1:0]) > 32'(MAX_PIXELS))
        begin
            frame_last_next = AW'(MAX_PIXELS - 1);
        end
        else
        begin
            frame_last_next = AW'(wr_data[dsdc_pkg::FRAME_W-1:0] - 1'b1);
        end
    end

    // Clamp, place the pixel in its frame
    always_comb
    begin
        cur_in  = pix_in.disparity[dsdc_pkg::DISP_W-1] ? '0 : pix_in.disparity[SW-1:0];
        idx_raw = pix_in.frame_start ? '0 : pixel_index_reg;
        idx_in  = (idx_raw > frame_last_reg) ? frame_last_reg : idx_raw;
        last_in = (idx_in == frame_last_reg);
        wr_in   = (weight_reg != '0);
    end

    // Hold configuration, pixel index and seeded flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg      <= dsdc_pkg::WEIGHT_RST;
            num_reg         <= dsdc_pkg::NUM_RST;
            offset_reg      <= dsdc_pkg::OFFSET_RST;
            gain_reg        <= dsdc_pkg::GAIN_RST;
            frame_last_reg  <= FRAME_LAST_RST;
            pixel_index_reg <= '0;
            seeded_reg      <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                dsdc_pkg::REG_EMA_WEIGHT:   weight_reg <= weight_next;
                dsdc_pkg::REG_DEPTH_NUM:    num_reg    <= wr_data;
                dsdc_pkg::REG_NORM_OFFSET:  offset_reg <= wr_data[dsdc_pkg::OFFSET_W-1:0];
                dsdc_pkg::REG_NORM_GAIN:    gain_reg   <= wr_data[dsdc_pkg::GAIN_W-1:0];
                dsdc_pkg::REG_FRAME_PIXELS:
                begin
                    frame_last_reg  <= frame_last_next;
                    pixel_index_reg <= '0;
                    seeded_reg      <= 1'b0;
                end
                default: ;
            endcase
        end
        else if (accept)
        begin
            pixel_index_reg <= last_in ? '0 : idx_in + 1'b1;
            if (wr_in && last_in)
            begin
                seeded_reg <= 1'b1;
            end
        end
    end

    // Advance valid bits and the forwarding flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            hit1_reg <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= pix_in.valid;
            hit1_reg <= pix_in.valid && v1_reg && wr1_reg && (idx1_reg == idx_in);
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
        end
    end

    // Frame store: read on accept, write from the blend stage
    always_ff @(posedge clk)
    begin
        if (en && v1_reg && wr1_reg)
        begin
            mem[idx1_reg] <= s1;
        end
        if (accept)
        begin
            rd_reg <= mem[idx_in];
        end
    end

    // Blend with the previous frame, forwarding the pixel just written
    always_comb
    begin
        prev1     = hit1_reg ? s2_reg : rd_reg;
        w_inv     = dsdc_pkg::WEIGHT_MAX - weight_reg;
        blend_sum = dsdc_pkg::BLEND_SUM_W'(weight_reg) * dsdc_pkg::BLEND_SUM_W'(prev1)
                  + dsdc_pkg::BLEND_SUM_W'(w_inv) * dsdc_pkg::BLEND_SUM_W'(cur1_reg)
                  + dsdc_pkg::BLEND_ROUND;
        s1        = blend1_reg ? blend_sum[dsdc_pkg::BLEND_SHIFT +: SW] : cur1_reg;
    end

    // Depth dividend with rounding, level product
    always_comb
    begin
        n_sum    = {1'b0, num_reg} + (dsdc_pkg::NUM_W + 1)'(s2_reg >> 1);
        lvl_diff = $signed({2'b00, s2_reg})
                 - $signed({offset_reg[dsdc_pkg::OFFSET_W-1], offset_reg});
        lvl_prod = dsdc_pkg::LVL_PROD_W'(lvl_diff)
                 * dsdc_pkg::LVL_PROD_W'($signed({1'b0, gain_reg}));
    end

    // Round and saturate the display level
    always_comb
    begin
        lvl_sum = lvl_prod3_reg + dsdc_pkg::LVL_PROD_W'(1 << (dsdc_pkg::LVL_SHIFT - 1));
        if (lvl_sum[dsdc_pkg::LVL_PROD_W-1])
        begin
            level3 = '0;
        end
        else if (|lvl_sum[dsdc_pkg::LVL_PROD_W-2:dsdc_pkg::LVL_SHIFT+dsdc_pkg::LEVEL_W])
        begin
            level3 = '1;
        end
        else
        begin
            level3 = lvl_sum[dsdc_pkg::LVL_SHIFT +: dsdc_pkg::LEVEL_W];
        end
        side3 = '{level: level3, smooth: s3_reg, last: last3_reg,
                  no_depth: zero3_reg, sat: sat3_reg};
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg      <= idx_in;
            cur1_reg      <= cur_in;
            last1_reg     <= last_in;
            wr1_reg       <= wr_in;
            blend1_reg    <= wr_in && seeded_reg;
            s2_reg        <= s1;
            last2_reg     <= last1_reg;
            s3_reg        <= s2_reg;
            last3_reg     <= last2_reg;
            zero3_reg     <= (s2_reg <= ONE_PX);
            sat3_reg      <= (n_sum[dsdc_pkg::NUM_W:dsdc_pkg::QUOT_W] >= (SW + 2)'(s2_reg));
            lo3_reg       <= n_sum[dsdc_pkg::QUOT_W-1:0];
            rem3_reg      <= n_sum[dsdc_pkg::QUOT_W +: SW];
            lvl_prod3_reg <= lvl_prod;
        end
    end

    dsdc_div_pipe u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (v3_reg),
        .dividend_lo (lo3_reg),
        .rem_init    (rem3_reg),
        .divisor     (s3_reg),
        .side_in     (side3),
        .out_valid   (dv_valid),
        .quotient    (dv_quot),
        .side_out    (dv_side)
    );

    // Drive the result channel
    assign pix_out.valid              = dv_valid;
    assign pix_out.depth_mm           = dv_side.no_depth ? '0 : (dv_side.sat ? '1 : dv_quot);
    assign pix_out.display_level      = dv_side.level;
    assign pix_out.smoothed_disparity = dv_side.smooth;
    assign pix_out.frame_end          = dv_side.last;

    `include "disparity_smooth_depth_convert_top_assert.svh"

    `DSDC_ASSERT_NEXT(a_frame_write_clears, wr_en && (wr_index == dsdc_pkg::REG_FRAME_PIXELS), (pixel_index_reg == '0) && !seeded_reg)
    `DSDC_ASSERT_NOW(a_depth_needs_disparity, pix_out.valid && (pix_out.depth_mm != '0), pix_out.smoothed_disparity > ONE_PX)
    `DSDC_ASSERT_NOW(a_forward_valid_item, hit1_reg, v1_reg && (idx1_reg <= frame_last_reg))

endmodule

/* hw/rtl/dsdc_div_pipe.sv */
// ----------------------------------------------------------------------------
// dsdc_div_pipe
// Pipelined restoring divider, DIV_BITS quotient bits per stage, with a
// sideband that travels in step with the quotient.
// ----------------------------------------------------------------------------
module dsdc_div_pipe (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [dsdc_pkg::QUOT_W-1:0]     dividend_lo,
    input  logic [dsdc_pkg::SMOOTH_W-1:0]   rem_init,
    input  logic [dsdc_pkg::SMOOTH_W-1:0]   divisor,
    input  dsdc_pkg::side_t                 side_in,
    output logic                            out_valid,
    output logic [dsdc_pkg::QUOT_W-1:0]     quotient,
    output dsdc_pkg::side_t                 side_out
);

    typedef struct packed {
        logic [dsdc_pkg::SMOOTH_W-1:0] rem;
        logic [dsdc_pkg::QUOT_W-1:0]   lo;
        logic [dsdc_pkg::QUOT_W-1:0]   q;
    } div_st_t;

    logic                          valid_reg [dsdc_pkg::DIV_STAGES];
    div_st_t                       st_reg    [dsdc_pkg::DIV_STAGES];
    logic [dsdc_pkg::SMOOTH_W-1:0] d_reg     [dsdc_pkg::DIV_STAGES];
    dsdc_pkg::side_t               side_reg  [dsdc_pkg::DIV_STAGES];
    div_st_t                       st_in;

    // One stage of shift, compare and subtract
    function automatic div_st_t div_step(div_st_t s, logic [dsdc_pkg::SMOOTH_W-1:0] d);
        div_st_t                     r;
        logic [dsdc_pkg::SMOOTH_W:0] t;
        r = s;
        for (int i = 0; i < dsdc_pkg::DIV_BITS; i++) begin
            t    = {r.rem, r.lo[dsdc_pkg::QUOT_W-1]};
            r.lo = {r.lo[dsdc_pkg::QUOT_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t   = t - {1'b0, d};
                r.q = {r.q[dsdc_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                r.q = {r.q[dsdc_pkg::QUOT_W-2:0], 1'b0};
            end
            r.rem = t[dsdc_pkg::SMOOTH_W-1:0];
        end
        return r;
    endfunction

    assign st_in = '{rem: rem_init, lo: dividend_lo, q: '0};

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < dsdc_pkg::DIV_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < dsdc_pkg::DIV_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Advance partial remainders, quotients and sideband
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]   <= div_step(st_in, divisor);
            d_reg[0]    <= divisor;
            side_reg[0] <= side_in;
            for (int k = 1; k < dsdc_pkg::DIV_STAGES; k++)
            begin
                st_reg[k]   <= div_step(st_reg[k-1], d_reg[k-1]);
                d_reg[k]    <= d_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[dsdc_pkg::DIV_STAGES-1];
    assign quotient  = st_reg[dsdc_pkg::DIV_STAGES-1].q;
    assign side_out  = side_reg[dsdc_pkg::DIV_STAGES-1];

endmodule
